// ===== rtl/htb_pkg.sv =====
// Shared widths, limits and controller/datapath interface types for the
// Huffman tree builder. No dependencies; imported by htb_ctrl, htb_datapath and the top.

package htb_pkg;

  localparam int MAX_LEAVES_DEF = 32;
  localparam int LEAF_W         = 16;
  localparam int WEIGHT_W       = 21;
  localparam int OUT_IDX_W      = 6;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store one leaf weight
    logic build_init;  // set up the first merge of a build
    logic scan;        // walk the node store for the two smallest weights
    logic merge;       // write the new node and present its record
    logic clear;       // empty the store after a build
  } htb_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic n_ge2;       // at least two leaves once the current leaf is stored
    logic scan_end;    // every existing node has been read this pass
    logic last_node;   // the node being built is the root
  } htb_status_t;

endpackage

// ===== rtl/htb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module htb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/htb_ctrl.sv =====
// Controller state machine for the Huffman tree builder.
// Depends on htb_pkg for the command and status types.

module htb_ctrl import htb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        is_last,
  input  htb_status_t status,
  output htb_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MERGE,
    S_CLEAR
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && is_last) begin
          state_next = status.n_ge2 ? S_SCAN : S_CLEAR;
        end
      end
      S_SCAN: begin
        if (status.scan_end) begin
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        state_next = status.last_node ? S_CLEAR : S_SCAN;
      end
      S_CLEAR: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  always_comb begin
    cmd.load       = accept;
    cmd.build_init = accept && is_last;
    cmd.scan       = (state == S_SCAN);
    cmd.merge      = (state == S_MERGE);
    cmd.clear      = (state == S_CLEAR);
  end

endmodule

// ===== rtl/htb_datapath.sv =====
// Datapath of the Huffman tree builder: weight RAM, merged flags, scan
// registers for the two smallest nodes, node counter and result registers.
// Depends on htb_pkg and htb_ram.

module htb_datapath import htb_pkg::*; #(
  parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  htb_cmd_t             cmd,
  input  logic [LEAF_W-1:0]    leaf_weight,
  output htb_status_t          status,
  output logic                 done,
  output logic [OUT_IDX_W-1:0] node_index,
  output logic [OUT_IDX_W-1:0] left_index,
  output logic [WEIGHT_W-1:0]  left_weight,
  output logic [OUT_IDX_W-1:0] right_index,
  output logic [WEIGHT_W-1:0]  right_weight,
  output logic                 final_merge
);

  localparam int SLOTS = 2 * MAX_LEAVES - 1;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(MAX_LEAVES + 1);

  logic [CNT_W-1:0]    leaf_count;
  logic [CNT_W-1:0]    n_next;
  logic                room;
  logic [SLOTS-1:0]    merged;

  logic [IDX_W-1:0]    node_k;
  logic [IDX_W-1:0]    final_k;
  logic [IDX_W-1:0]    scan_i;

  // Read pipeline: the RAM returns the weight in the cycle after the address.
  logic                rd_vld;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_merged;
  logic [WEIGHT_W-1:0] rd_weight;

  // Running smallest (a) and second smallest (b) unmerged nodes.
  logic                a_vld;
  logic [IDX_W-1:0]    a_idx;
  logic [WEIGHT_W-1:0] a_w;
  logic                b_vld;
  logic [IDX_W-1:0]    b_idx;
  logic [WEIGHT_W-1:0] b_w;

  logic [WEIGHT_W:0]   sum_raw;
  logic [WEIGHT_W-1:0] sum_sat;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WEIGHT_W-1:0] ram_wdata;

  assign room    = (leaf_count < CNT_W'(MAX_LEAVES));
  assign n_next  = leaf_count + CNT_W'(room);
  assign sum_raw = {1'b0, a_w} + {1'b0, b_w};
  assign sum_sat = sum_raw[WEIGHT_W] ? WEIGHT_MAX : sum_raw[WEIGHT_W-1:0];

  assign ram_we    = (cmd.load && room) || cmd.merge;
  assign ram_waddr = cmd.merge ? node_k : IDX_W'(leaf_count);
  assign ram_wdata = cmd.merge ? sum_sat : WEIGHT_W'(leaf_weight);

  htb_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (SLOTS)
  ) u_weight_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_i),
    .rdata (rd_weight)
  );

  always_comb begin
    status.n_ge2     = (n_next >= CNT_W'(2));
    status.scan_end  = (scan_i == node_k);
    status.last_node = (node_k == final_k);
  end

  // Control state: counts and scan progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= '0;
      scan_i     <= '0;
      rd_vld     <= 1'b0;
      a_vld      <= 1'b0;
      b_vld      <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= cmd.merge;
      if (cmd.load && room) begin
        leaf_count <= n_next;
      end
      if (cmd.build_init || cmd.merge) begin
        scan_i <= '0;
        rd_vld <= 1'b0;
        a_vld  <= 1'b0;
        b_vld  <= 1'b0;
      end else if (cmd.scan) begin
        rd_vld <= (scan_i != node_k);
        if (scan_i != node_k) begin
          scan_i <= scan_i + IDX_W'(1);
        end
      end else begin
        rd_vld <= 1'b0;
      end
      // Order by weight, ties to the earlier index; nodes arrive in index order.
      if (rd_vld && !rd_merged && !cmd.merge) begin
        if (!a_vld) begin
          a_vld <= 1'b1;
        end else if (rd_weight < a_w) begin
          b_vld <= 1'b1;
        end else if (!b_vld || rd_weight < b_w) begin
          b_vld <= 1'b1;
        end
      end
      if (cmd.clear) begin
        leaf_count <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_idx    <= scan_i;
    rd_merged <= merged[scan_i];
    // A node's flag is written whenever the node itself is stored, so every
    // node read during a build carries a flag from that build.
    if (ram_we) begin
      merged[ram_waddr] <= 1'b0;
    end
    if (cmd.merge) begin
      merged[a_idx] <= 1'b1;
      merged[b_idx] <= 1'b1;
    end
    if (cmd.build_init) begin
      node_k  <= IDX_W'(n_next);
      final_k <= IDX_W'({n_next, 1'b0} - (CNT_W + 1)'(2));
    end else if (cmd.merge) begin
      node_k <= node_k + IDX_W'(1);
    end
    if (rd_vld && !rd_merged && !cmd.merge) begin
      if (!a_vld) begin
        a_idx <= rd_idx;
        a_w   <= rd_weight;
      end else if (rd_weight < a_w) begin
        b_idx <= a_idx;
        b_w   <= a_w;
        a_idx <= rd_idx;
        a_w   <= rd_weight;
      end else if (!b_vld || rd_weight < b_w) begin
        b_idx <= rd_idx;
        b_w   <= rd_weight;
      end
    end
    if (cmd.merge) begin
      node_index   <= OUT_IDX_W'(node_k);
      left_index   <= OUT_IDX_W'(a_idx);
      left_weight  <= a_w;
      right_index  <= OUT_IDX_W'(b_idx);
      right_weight <= b_w;
      final_merge  <= (node_k == final_k);
    end
  end

endmodule

// ===== rtl/huffman_tree_builder.sv =====
// Channel   Signals                               Transfer when
// input     start, busy, leaf_weight, is_last     start high and busy low
// result    done, node_index ... final_merge      done high (one cycle, no stall)
//
// A leaf weight is taken whenever start is high and busy low; back-to-back loads are accepted.
// The leaf flagged is_last starts a build over n leaves: each node k takes one
// weight RAM read per existing node, a drain and a merge, and the build ends
// with a clearing step, with busy high throughout.
// Fewer than two leaves gives no record; busy is high only for the clearing step.
// Reset (rst, synchronous) empties the store; merged flags are written as each
// node is stored, so no clearing pass is needed.
// Depends on htb_pkg, htb_ctrl, htb_datapath and htb_ram.

module huffman_tree_builder import htb_pkg::*; #(
  parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [LEAF_W-1:0]    leaf_weight,
  input  logic                 is_last,
  output logic                 done,
  output logic [OUT_IDX_W-1:0] node_index,
  output logic [OUT_IDX_W-1:0] left_index,
  output logic [WEIGHT_W-1:0]  left_weight,
  output logic [OUT_IDX_W-1:0] right_index,
  output logic [WEIGHT_W-1:0]  right_weight,
  output logic                 final_merge
);

  htb_cmd_t    cmd;
  htb_status_t status;

  htb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .is_last (is_last),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  htb_datapath #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .leaf_weight  (leaf_weight),
    .status       (status),
    .done         (done),
    .node_index   (node_index),
    .left_index   (left_index),
    .left_weight  (left_weight),
    .right_index  (right_index),
    .right_weight (right_weight),
    .final_merge  (final_merge)
  );

  // A record only appears while a build is in progress.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result transfer outside a build");

  // The root record ends the build on the following cycle.
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    done && final_merge |=> !busy)
    else $error("build did not end after the root merge");

  // The left child is never heavier than the right one.
  a_order: assert property (@(posedge clk) disable iff (rst)
    done |-> (left_weight <= right_weight))
    else $error("children out of order");

  // The two children of a merge are distinct nodes.
  a_distinct: assert property (@(posedge clk) disable iff (rst)
    done |-> (left_index != right_index))
    else $error("node merged with itself");

endmodule

// ===== bench/huffman_tree_builder_tb.sv =====
// Self-checking bench for huffman_tree_builder: leaf sets are pushed through the
// start/busy port and every merge record is compared against an in-bench model.
// Depends on htb_pkg and the huffman_tree_builder rtl.
`timescale 1ns / 1ps

module huffman_tree_builder_tb;
  import htb_pkg::*;

  localparam int MAX_LEAVES   = MAX_LEAVES_DEF;
  localparam int NODE_SLOTS   = 2 * MAX_LEAVES - 1;
  localparam int RANDOM_LEAVES = 260;
  localparam int IDLE_LIMIT   = 20000;
  localparam int END_DRAIN    = 50;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] node;
    logic [OUT_IDX_W-1:0] left_idx;
    logic [WEIGHT_W-1:0]  left_w;
    logic [OUT_IDX_W-1:0] right_idx;
    logic [WEIGHT_W-1:0]  right_w;
    logic                 root;
  } merge_rec_t;

  typedef enum int { W_FULL, W_TIES, W_EXTREME, W_SMALL } weight_mix_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [LEAF_W-1:0]    leaf_weight = '0;
  logic                 is_last = 1'b0;
  logic                 done;
  logic [OUT_IDX_W-1:0] node_index;
  logic [OUT_IDX_W-1:0] left_index;
  logic [WEIGHT_W-1:0]  left_weight;
  logic [OUT_IDX_W-1:0] right_index;
  logic [WEIGHT_W-1:0]  right_weight;
  logic                 final_merge;

  // Model state of the node store.
  logic [WEIGHT_W-1:0] weight_store [NODE_SLOTS];
  logic                merged_flag [NODE_SLOTS];
  int                  stored_leaves;

  merge_rec_t pending_merges[$];
  int         max_gap = 6;
  int         leaves_sent = 0;
  int         builds_started = 0;
  int         merges_checked = 0;
  int         mismatches = 0;
  int         idle_cycles = 0;

  huffman_tree_builder dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .leaf_weight  (leaf_weight),
    .is_last      (is_last),
    .done         (done),
    .node_index   (node_index),
    .left_index   (left_index),
    .left_weight  (left_weight),
    .right_index  (right_index),
    .right_weight (right_weight),
    .final_merge  (final_merge)
  );

  always #1 clk = ~clk;

  task automatic empty_store();
    for (int i = 0; i < NODE_SLOTS; i++) begin
      weight_store[i] = '0;
      merged_flag[i]  = 1'b0;
    end
    stored_leaves = 0;
  endtask

  // Lightest unmerged node below limit, ordered by weight then index.
  function automatic int lightest(int limit, int skip);
    int best;
    best = -1;
    for (int i = 0; i < limit; i++) begin
      if (!merged_flag[i] && i != skip &&
          (best < 0 || weight_store[i] < weight_store[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  task automatic store_leaf(input logic [LEAF_W-1:0] w, input logic last);
    int            n;
    int            lo;
    int            hi;
    logic [WEIGHT_W:0] sum;
    merge_rec_t    rec;
    if (stored_leaves < MAX_LEAVES) begin
      weight_store[stored_leaves] = WEIGHT_W'(w);
      merged_flag[stored_leaves]  = 1'b0;
      stored_leaves++;
    end
    if (last) begin
      n = stored_leaves;
      builds_started++;
      for (int k = n; n >= 2 && k < 2 * n - 1 && k < NODE_SLOTS; k++) begin
        lo  = lightest(k, -1);
        hi  = lightest(k, lo);
        sum = {1'b0, weight_store[lo]} + {1'b0, weight_store[hi]};
        if (sum > {1'b0, WEIGHT_MAX}) begin
          sum = {1'b0, WEIGHT_MAX};
        end
        rec.node      = OUT_IDX_W'(k);
        rec.left_idx  = OUT_IDX_W'(lo);
        rec.left_w    = weight_store[lo];
        rec.right_idx = OUT_IDX_W'(hi);
        rec.right_w   = weight_store[hi];
        rec.root      = (k == 2 * n - 2);
        pending_merges.push_back(rec);
        weight_store[k] = sum[WEIGHT_W-1:0];
        merged_flag[k]  = 1'b0;
        merged_flag[lo] = 1'b1;
        merged_flag[hi] = 1'b1;
      end
      empty_store();
    end
  endtask

  // Offers one leaf after a random gap and returns at the edge of its transfer.
  task automatic send_leaf(input logic [LEAF_W-1:0] w, input logic last);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    leaf_weight <= w;
    is_last     <= last;
    do @(posedge clk); while (busy);
    store_leaf(w, last);
    leaves_sent++;
  endtask

  task automatic wait_for_merges();
    start <= 1'b0;
    do @(posedge clk); while (pending_merges.size() != 0);
  endtask

  function automatic logic [LEAF_W-1:0] pick_weight(weight_mix_t mix);
    case (mix)
      W_TIES:    return LEAF_W'($urandom_range(0, 3));
      W_EXTREME: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      W_SMALL:   return LEAF_W'($urandom_range(0, 255));
      default:   return LEAF_W'($urandom);
    endcase
  endfunction

  task automatic send_set(int size, weight_mix_t mix);
    for (int i = 0; i < size; i++) begin
      send_leaf(pick_weight(mix), i == size - 1);
    end
  endtask

  task automatic test_single_leaf();
    send_leaf(16'd1234, 1'b1);
    send_leaf('1, 1'b1);
  endtask

  task automatic test_extreme_weights();
    send_leaf('1, 1'b0);
    send_leaf('0, 1'b0);
    send_leaf('1, 1'b1);
  endtask

  task automatic test_equal_weights();
    repeat (3) send_leaf(16'd5, 1'b0);
    send_leaf(16'd5, 1'b1);
  endtask

  // Leaves past the bound are dropped, and the dropped last one still builds.
  task automatic test_overflow();
    max_gap = 0;
    for (int i = 0; i < MAX_LEAVES + 4; i++) begin
      send_leaf('1 - LEAF_W'(i), i == MAX_LEAVES + 3);
    end
    max_gap = 6;
  endtask

  task automatic test_drain_pause();
    send_set(5, W_FULL);
    wait_for_merges();
    send_set(3, W_TIES);
    wait_for_merges();
  endtask

  task automatic test_random_sets();
    int          first;
    int          size;
    int          sel;
    weight_mix_t mix;
    first = leaves_sent;
    while (leaves_sent - first < RANDOM_LEAVES) begin
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
      sel     = $urandom_range(0, 99);
      mix     = weight_mix_t'($urandom_range(0, 3));
      if (sel < 12) begin
        size = 1;
      end else if (sel < 82) begin
        size = $urandom_range(2, 8);
      end else if (sel < 96) begin
        size = $urandom_range(9, 20);
      end else begin
        size = $urandom_range(MAX_LEAVES - 2, MAX_LEAVES + 4);
      end
      send_set(size, mix);
      if ($urandom_range(0, 19) == 0) begin
        wait_for_merges();
      end
    end
  endtask

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    merge_rec_t exp;
    if (!rst && done) begin
      if (pending_merges.size() == 0) begin
        $error("merge record with nothing expected: node_index %0d", node_index);
        mismatches++;
      end else begin
        exp = pending_merges.pop_front();
        check_field("node_index", exp.node, node_index);
        check_field("left_index", exp.left_idx, left_index);
        check_field("left_weight", exp.left_w, left_weight);
        check_field("right_index", exp.right_idx, right_index);
        check_field("right_weight", exp.right_w, right_weight);
        check_field("final_merge", exp.root, final_merge);
        merges_checked++;
      end
    end
  end

  // Ends the run when neither a leaf nor a record has moved for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    empty_store();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_single_leaf();
    test_extreme_weights();
    test_equal_weights();
    test_overflow();
    test_drain_pause();
    test_random_sets();
    wait_for_merges();
    repeat (END_DRAIN) @(posedge clk);
    $display("Sent %0d leaves in %0d builds, including overflow and single-leaf builds.",
             leaves_sent, builds_started);
    $display("Checked %0d merge records, %0d mismatches.", merges_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== huffman_tree_builder.f =====
rtl/htb_pkg.sv
rtl/htb_ram.sv
rtl/htb_ctrl.sv
rtl/htb_datapath.sv
rtl/huffman_tree_builder.sv
bench/huffman_tree_builder_tb.sv
